// ===== rtl/rqpb_pkg.sv =====
// Shared types and codes for the ring queue with peek and burst.
`timescale 1ns / 1ps

package rqpb_pkg;

  typedef enum logic [2:0] {
    CMD_RESET      = 3'd0,
    CMD_ENQUEUE    = 3'd1,
    CMD_BURST      = 3'd2,
    CMD_DROP_HEAD  = 3'd3,
    CMD_WRITE_FREE = 3'd4,
    CMD_COMMIT     = 3'd5,
    CMD_PEEK       = 3'd6,
    CMD_PEEK_LAST  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_ZERO    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FieldW = 8;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned MinSlots = 2;
  localparam int unsigned ResetSlots = 256;

  // Decoded command as it travels from the front end to the execution unit.
  typedef struct packed {
    cmd_e              op;
    logic [DataW-1:0]  data;
    logic [FieldW-1:0] offset;
    logic [FieldW-1:0] count;
  } item_t;

endpackage

// ===== rtl/rqpb_cmd_if.sv =====
// Command channel interface: valid/ready plus one command item.
`timescale 1ns / 1ps

interface rqpb_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] node_data;
  logic [7:0]  offset;
  logic [7:0]  count;

  modport source (output valid, output command, output node_data, output offset,
                  output count, input ready);
  modport sink   (input valid, input command, input node_data, input offset,
                  input count, output ready);
endinterface

// ===== rtl/rqpb_res_if.sv =====
// Result channel interface: valid/ready plus one result item.
`timescale 1ns / 1ps

interface rqpb_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] node_data_res;
  logic [7:0]  entries;
  logic [7:0]  free_slots;
  logic        last;

  modport source (output valid, output status, output node_data_res, output entries,
                  output free_slots, output last, input ready);
  modport sink   (input valid, input status, input node_data_res, input entries,
                  input free_slots, input last, output ready);
endinterface

// ===== rtl/rqpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rqpb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rqpb_front.sv =====
// Front end: takes command transfers, decodes them and buffers two in a small queue.
`timescale 1ns / 1ps

module rqpb_front import rqpb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rqpb_cmd_if.sink cmd_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_ready_i
);

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;
  item_t       item_in;

  assign cmd_i.ready  = (fill_q != 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  assign push = cmd_i.valid && cmd_i.ready;
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    item_in.op     = cmd_e'(cmd_i.command);
    item_in.data   = cmd_i.node_data;
    item_in.offset = cmd_i.offset;
    item_in.count  = cmd_i.count;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== rtl/rqpb_back.sv =====
// Execution unit: ring indices, node RAM access and the result register.
`timescale 1ns / 1ps

module rqpb_back import rqpb_pkg::*; #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned NODE_BITS = 64,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            item_valid_i,
  input  item_t           item_i,
  output logic            item_ready_o,
  rqpb_res_if.source      res_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = ((CNT_W > FieldW) ? CNT_W : FieldW) + 1;
  localparam int unsigned BW    = $clog2(MAX_BURST + 1);
  localparam int unsigned RstSlots = (DEPTH < ResetSlots) ? DEPTH : ResetSlots;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]     tail_q, tail_d;
  logic [IDX_W-1:0]     used_q, used_d;
  logic [CNT_W-1:0]     max_q, max_d;
  logic [BW-1:0]        remain_q, remain_d;

  logic                 out_valid_q;
  status_e              out_status_q, st_new;
  logic [DataW-1:0]     out_data_q, data_new;
  logic                 out_last_q, last_new;
  logic                 load_out, out_free;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [NODE_BITS-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]     free_w;
  logic [CNT_W-1:0]     cfg_max;
  logic [SUM_W-1:0]     take_min;
  logic [BW-1:0]        burst_n;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s,
                                                input logic [CNT_W-1:0] m);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(m)) ? s - SUM_W'(m) : s;
    return IDX_W'(r);
  endfunction

  assign free_w   = max_q - CNT_W'(1) - CNT_W'(used_q);
  assign out_free = !out_valid_q || res_o.ready;

  // clamp of the slot count register
  always_comb begin
    if (cfg_data_i < CfgW'(MinSlots)) begin
      cfg_max = CNT_W'(MinSlots);
    end else if (32'(cfg_data_i) > DEPTH) begin
      cfg_max = CNT_W'(DEPTH);
    end else begin
      cfg_max = CNT_W'(cfg_data_i);
    end
  end

  // burst length: min(count, entries, MAX_BURST)
  always_comb begin
    take_min = (SUM_W'(item_i.count) < SUM_W'(used_q)) ? SUM_W'(item_i.count)
                                                       : SUM_W'(used_q);
    burst_n  = (take_min > SUM_W'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(take_min);
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    used_d       = used_q;
    max_d        = max_q;
    remain_d     = remain_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_wdata    = NODE_BITS'(item_i.data);
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    load_out     = 1'b0;
    st_new       = STAT_OK;
    data_new     = '0;
    last_new     = 1'b1;
    item_ready_o = 1'b0;

    if (cfg_we_i) begin
      max_d   = cfg_max;
      head_d  = '0;
      tail_d  = '0;
      used_d  = '0;
      state_d = ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i && out_free) begin
            item_ready_o = 1'b1;
            load_out     = 1'b1;
            unique case (item_i.op)
              CMD_RESET: begin
                head_d = '0;
                tail_d = '0;
                used_d = '0;
              end
              CMD_ENQUEUE: begin
                if (free_w == '0) begin
                  st_new = STAT_NO_ROOM;
                end else begin
                  ram_we = 1'b1;
                  tail_d = wrap_idx(SUM_W'(tail_q) + SUM_W'(1), max_q);
                  used_d = used_q + IDX_W'(1);
                end
              end
              CMD_BURST: begin
                if (item_i.count == '0) begin
                  st_new = STAT_ZERO;
                end else if (used_q == '0) begin
                  st_new = STAT_EMPTY;
                end else begin
                  load_out  = 1'b0;
                  ram_re    = 1'b1;
                  ram_raddr = head_q;
                  head_d    = wrap_idx(SUM_W'(head_q) + SUM_W'(1), max_q);
                  used_d    = IDX_W'(SUM_W'(used_q) - SUM_W'(burst_n));
                  remain_d  = burst_n - BW'(1);
                  state_d   = ST_READ;
                end
              end
              CMD_DROP_HEAD: begin
                if (used_q == '0) begin
                  st_new = STAT_EMPTY;
                end else begin
                  head_d = wrap_idx(SUM_W'(head_q) + SUM_W'(1), max_q);
                  used_d = used_q - IDX_W'(1);
                end
              end
              CMD_WRITE_FREE: begin
                if (SUM_W'(item_i.offset) >= SUM_W'(free_w)) begin
                  st_new = STAT_EMPTY;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = wrap_idx(SUM_W'(tail_q) + SUM_W'(item_i.offset), max_q);
                end
              end
              CMD_COMMIT: begin
                if (SUM_W'(item_i.count) > SUM_W'(free_w)) begin
                  st_new = STAT_NO_ROOM;
                end else begin
                  tail_d = wrap_idx(SUM_W'(tail_q) + SUM_W'(item_i.count), max_q);
                  used_d = IDX_W'(SUM_W'(used_q) + SUM_W'(item_i.count));
                end
              end
              CMD_PEEK: begin
                if (SUM_W'(item_i.offset) >= SUM_W'(used_q)) begin
                  st_new = STAT_EMPTY;
                end else begin
                  load_out  = 1'b0;
                  ram_re    = 1'b1;
                  ram_raddr = wrap_idx(SUM_W'(head_q) + SUM_W'(item_i.offset), max_q);
                  remain_d  = '0;
                  state_d   = ST_READ;
                end
              end
              CMD_PEEK_LAST: begin
                if (used_q == '0) begin
                  st_new = STAT_EMPTY;
                end else begin
                  load_out  = 1'b0;
                  ram_re    = 1'b1;
                  ram_raddr = (tail_q == '0) ? IDX_W'(max_q - CNT_W'(1))
                                             : tail_q - IDX_W'(1);
                  remain_d  = '0;
                  state_d   = ST_READ;
                end
              end
            endcase
          end
        end
        ST_READ: begin
          // RAM data is valid here and held until the result register takes it
          if (out_free) begin
            load_out = 1'b1;
            data_new = DataW'(ram_rdata);
            last_new = (remain_q == '0);
            if (remain_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              head_d    = wrap_idx(SUM_W'(head_q) + SUM_W'(1), max_q);
              remain_d  = remain_q - BW'(1);
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      max_q       <= CNT_W'(RstSlots);
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      max_q       <= max_d;
      remain_q    <= remain_d;
      out_valid_q <= load_out ? 1'b1 : (out_valid_q && !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= st_new;
      out_data_q   <= data_new;
      out_last_q   <= last_new;
    end
  end

  rqpb_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entries and free slots follow the ring state, which holds while a result waits
  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.node_data_res = out_data_q;
  assign res_o.last          = out_last_q;
  assign res_o.entries       = FieldW'(used_q);
  assign res_o.free_slots    = FieldW'(free_w);

`ifndef SYNTHESIS
  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(used_q) < max_q) && (CNT_W'(head_q) < max_q) && (CNT_W'(tail_q) < max_q))
    else $error("ring index or fill out of range");

  a_fill_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |->
      ((tail_q >= head_q) ? (SUM_W'(tail_q) - SUM_W'(head_q) == SUM_W'(used_q))
                          : (SUM_W'(tail_q) + SUM_W'(max_q) - SUM_W'(head_q)
                             == SUM_W'(used_q))))
    else $error("fill count disagrees with head and tail");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_o.ready && !out_last_q) |=> out_valid_q)
    else $error("burst result gap after a non-final transfer");
`endif

endmodule

// ===== rtl/ring_queue_with_peek_and_burst_unit.sv =====
// Top level of the ring queue with peek and burst dequeue.
// Path: a command transfer passes the front-end queue and the result register;
// peeks and bursts also go through the registered read of the node RAM.
// Throughput: one command per cycle for non-reading commands while results are
// taken; a peek or burst holds off new commands until the single RAM read port is done.
// Reset: rst_ni clears head, tail and fill, sets the slot count to its default
// and empties the command queue; node RAM contents are not cleared.
`timescale 1ns / 1ps

module ring_queue_with_peek_and_burst_unit import rqpb_pkg::*; #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned NODE_BITS = 64,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  rqpb_cmd_if.sink        cmd_i,
  rqpb_res_if.source      res_o
);

  // Decoded commands between front end and execution unit
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Front end: accepts transfers while the back end is busy, two deep
  rqpb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  // Back end: ring pointers, node RAM, result register.
  // The slot count register lives here; a write empties the ring.
  rqpb_back #(
    .DEPTH     (DEPTH),
    .NODE_BITS (NODE_BITS),
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_o        (res_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the ring queue: directed corner cases, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import rqpb_pkg::*;

  // Store depth and burst cap of the unit as built, and the run's limits.
  localparam int unsigned RING_DEPTH   = 256;
  localparam int unsigned BURST_CAP    = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned PHASES       = 10;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One expected result transfer.
  typedef struct {
    status_e          status;
    logic [DataW-1:0] node;
    logic [7:0]       entries;
    logic [7:0]       free_slots;
    logic             last;
  } ring_result_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_data_i;

  rqpb_cmd_if cmd_if ();
  rqpb_res_if res_if ();

  ring_queue_with_peek_and_burst_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  // Mirror of the ring: node store, which slots hold real data, indices and size.
  logic [DataW-1:0] ring_nodes [RING_DEPTH];
  bit               slot_written [RING_DEPTH];
  int unsigned      ring_head;
  int unsigned      ring_tail;
  int unsigned      ring_slots;
  ring_result_t     pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned transfers_in;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned op_hits [8];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Ring arithmetic, all modulo the slot count currently in force.
  // ---------------------------------------------------------------------------
  function automatic int unsigned ring_wrap(int unsigned a, int unsigned b);
    return (a + b) % ring_slots;
  endfunction

  function automatic int unsigned ring_used();
    return (ring_tail + ring_slots - ring_head) % ring_slots;
  endfunction

  function automatic int unsigned ring_free();
    return ring_slots - 1 - ring_used();
  endfunction

  // Slots from the tail onward that already hold data, up to limit. A commit
  // must never pull a never-written slot into the queue, as reading it later
  // would return whatever the RAM powered up with.
  function automatic int unsigned written_from_tail(int unsigned limit);
    int unsigned n;
    n = 0;
    while (n < limit && slot_written[ring_wrap(ring_tail, n)]) n++;
    return n;
  endfunction

  function automatic logic [DataW-1:0] random_node();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted command to the mirror and queues the
  // result transfers it must cause. Entries and free slots are reported as
  // they stand after the whole command, bursts included.
  // ---------------------------------------------------------------------------
  task automatic predict_command(cmd_e op, logic [DataW-1:0] node, logic [7:0] off,
                                 logic [7:0] cnt);
    status_e          st;
    logic [DataW-1:0] read_node;
    logic [DataW-1:0] burst_nodes [$];
    ring_result_t     r;
    int unsigned      n;
    st        = STAT_OK;
    read_node = '0;
    case (op)
      CMD_RESET: begin
        ring_head = 0;
        ring_tail = 0;
      end
      CMD_ENQUEUE: begin
        if (ring_free() == 0) begin
          st = STAT_NO_ROOM;
        end else begin
          ring_nodes[ring_tail]   = node;
          slot_written[ring_tail] = 1'b1;
          ring_tail               = ring_wrap(ring_tail, 1);
        end
      end
      CMD_BURST: begin
        if (cnt == 0) begin
          st = STAT_ZERO;
        end else if (ring_used() == 0) begin
          st = STAT_EMPTY;
        end else begin
          n = ring_used();
          if (cnt < n) n = cnt;
          if (n > BURST_CAP) n = BURST_CAP;
          repeat (n) begin
            burst_nodes.push_back(ring_nodes[ring_head]);
            ring_head = ring_wrap(ring_head, 1);
          end
        end
      end
      CMD_DROP_HEAD: begin
        if (ring_used() == 0) st = STAT_EMPTY;
        else ring_head = ring_wrap(ring_head, 1);
      end
      CMD_WRITE_FREE: begin
        if (off >= ring_free()) begin
          st = STAT_EMPTY;
        end else begin
          ring_nodes[ring_wrap(ring_tail, off)]   = node;
          slot_written[ring_wrap(ring_tail, off)] = 1'b1;
        end
      end
      CMD_COMMIT: begin
        if (cnt > ring_free()) st = STAT_NO_ROOM;
        else ring_tail = ring_wrap(ring_tail, cnt);
      end
      CMD_PEEK: begin
        if (off >= ring_used()) st = STAT_EMPTY;
        else read_node = ring_nodes[ring_wrap(ring_head, off)];
      end
      default: begin
        if (ring_used() == 0) st = STAT_EMPTY;
        else read_node = ring_nodes[ring_wrap(ring_tail, ring_slots - 1)];
      end
    endcase
    r.entries    = 8'(ring_used());
    r.free_slots = 8'(ring_free());
    if (burst_nodes.size() != 0) begin
      foreach (burst_nodes[i]) begin
        r.status = STAT_OK;
        r.node   = burst_nodes[i];
        r.last   = (i == burst_nodes.size() - 1);
        pending_results.push_back(r);
      end
    end else begin
      r.status = st;
      r.node   = read_node;
      r.last   = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command side. Valid is only lowered when a gap is taken, so back-to-back
  // transfers never see valid dropped and raised within one time step.
  // ---------------------------------------------------------------------------
  task automatic send_command(cmd_e op, logic [DataW-1:0] node, logic [7:0] off,
                              logic [7:0] cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= op;
    cmd_if.node_data <= node;
    cmd_if.offset    <= off;
    cmd_if.count     <= cnt;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_command(op, node, off, cnt);
    transfers_in++;
    op_hits[op]++;
  endtask

  // Hold off the command side until every queued result has come back.
  // The wait always passes through a clock edge, so valid is never lowered and raised in one step.
  task automatic wait_results_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Register write, only with the unit idle. The write also empties the ring.
  task automatic write_slot_count(logic [CfgW-1:0] value);
    wait_results_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (value < MinSlots) ring_slots = MinSlots;
    else if (value > RING_DEPTH) ring_slots = RING_DEPTH;
    else ring_slots = value;
    ring_head = 0;
    ring_tail = 0;
  endtask

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 53;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and an in-order check of each transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d node %0h entries %0d",
               res_if.status, res_if.node_data_res, res_if.entries);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("status", want.status, res_if.status);
        check_field("node_data_res", want.node, res_if.node_data_res);
        check_field("entries", want.entries, res_if.entries);
        check_field("free_slots", want.free_slots, res_if.free_slots);
        check_field("last", want.last, res_if.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every reading or removing command on a fresh, empty ring of 256 slots.
  task automatic test_empty_ring();
    set_idling(IDLE_NONE);
    send_command(CMD_BURST, '0, 8'd0, 8'd5);
    send_command(CMD_BURST, '0, 8'd0, 8'd0);
    send_command(CMD_DROP_HEAD, '0, 8'd0, 8'd0);
    send_command(CMD_PEEK_LAST, '0, 8'd0, 8'd0);
    send_command(CMD_PEEK, '0, 8'd0, 8'd0);
  endtask

  // Each command in its ok form, peeks, writes and commits also failing; extremes of data and offset.
  task automatic test_basic_ops();
    set_idling(IDLE_BOTH);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_ENQUEUE, '1, 8'hFF, 8'hFF);
    send_command(CMD_ENQUEUE, '0, 8'd0, 8'd0);
    send_command(CMD_PEEK, '0, 8'd0, 8'd0);
    send_command(CMD_PEEK, '0, 8'd2, 8'd0);
    send_command(CMD_PEEK, '0, 8'd3, 8'd0);      // one past the last entry
    send_command(CMD_PEEK, '0, 8'd255, 8'd0);
    send_command(CMD_PEEK_LAST, '0, 8'd0, 8'd0);
    send_command(CMD_WRITE_FREE, random_node(), 8'd0, 8'd0);
    send_command(CMD_WRITE_FREE, random_node(), 8'd251, 8'd0);  // last free slot
    send_command(CMD_WRITE_FREE, random_node(), 8'd252, 8'd0);  // beyond it
    send_command(CMD_COMMIT, '0, 8'd0, 8'd1);
    send_command(CMD_COMMIT, '0, 8'd0, 8'd0);
    send_command(CMD_COMMIT, '0, 8'd0, 8'd255);  // more than is free
    send_command(CMD_BURST, '0, 8'd0, 8'd2);
    send_command(CMD_BURST, '0, 8'd0, 8'd255);   // asks for more than is held
    send_command(CMD_DROP_HEAD, '0, 8'd0, 8'd0);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_DROP_HEAD, '0, 8'd0, 8'd0);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_RESET, '0, 8'd0, 8'd0);
  endtask

  // Smallest ring, one node of capacity, reached also by values below the floor.
  task automatic test_two_slot_ring();
    set_idling(IDLE_SENDER);
    write_slot_count(9'd2);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_WRITE_FREE, random_node(), 8'd0, 8'd0);
    send_command(CMD_COMMIT, '0, 8'd0, 8'd1);
    send_command(CMD_PEEK, '0, 8'd0, 8'd0);
    send_command(CMD_PEEK_LAST, '0, 8'd0, 8'd0);
    send_command(CMD_BURST, '0, 8'd0, 8'd255);
    send_command(CMD_DROP_HEAD, '0, 8'd0, 8'd0);
    send_command(CMD_COMMIT, '0, 8'd0, 8'd0);
    write_slot_count(9'd0);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_PEEK, '0, 8'd1, 8'd0);
    send_command(CMD_BURST, '0, 8'd0, 8'd1);
    write_slot_count(9'd1);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_DROP_HEAD, '0, 8'd0, 8'd0);
  endtask

  // Ring one node past the burst cap, filled to its last node and drained by
  // a capped burst and its remainder.
  task automatic test_full_ring();
    set_idling(IDLE_RECEIVER);
    write_slot_count(9'd66);
    repeat (65) send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_ENQUEUE, random_node(), 8'd0, 8'd0);
    send_command(CMD_COMMIT, '0, 8'd0, 8'd1);
    send_command(CMD_WRITE_FREE, random_node(), 8'd0, 8'd0);
    send_command(CMD_PEEK, '0, 8'd64, 8'd0);
    send_command(CMD_PEEK, '0, 8'd65, 8'd0);
    send_command(CMD_PEEK_LAST, '0, 8'd0, 8'd0);
    // Let everything drain before the bursts go in back to back.
    wait_results_drained();
    repeat (2) send_command(CMD_BURST, '0, 8'd0, 8'd255);
    send_command(CMD_BURST, '0, 8'd0, 8'd1);
  endtask

  // One random command, or a short staged write-then-commit sequence.
  task automatic send_random_command();
    int unsigned pick;
    int unsigned used;
    int unsigned room;
    int unsigned k;
    cmd_e        op;
    logic [7:0]  off;
    logic [7:0]  cnt;
    if ($urandom_range(0, 39) == 0) wait_results_drained();
    used = ring_used();
    room = ring_free();
    pick = $urandom_range(0, 99);
    off  = 8'($urandom);
    cnt  = 8'($urandom);
    if (pick < 8 && room > 0) begin
      // stage nodes in the free slots past the tail, then publish them at once
      k = $urandom_range(1, (room < 6) ? room : 6);
      for (int unsigned j = 0; j < k; j++) begin
        send_command(CMD_WRITE_FREE, random_node(), 8'(j), 8'($urandom));
      end
      send_command(CMD_COMMIT, random_node(), 8'($urandom), 8'(k));
      return;
    end
    if (pick < 12) op = CMD_RESET;
    else if (pick < 42) op = CMD_ENQUEUE;
    else if (pick < 57) op = CMD_BURST;
    else if (pick < 64) op = CMD_DROP_HEAD;
    else if (pick < 74) op = CMD_WRITE_FREE;
    else if (pick < 82) op = CMD_COMMIT;
    else if (pick < 93) op = CMD_PEEK;
    else op = CMD_PEEK_LAST;
    case (op)
      CMD_BURST: begin
        case ($urandom_range(0, 9))
          0: cnt = 8'd0;
          1: cnt = 8'($urandom_range(128, 255));
          default: cnt = 8'($urandom_range(1, (used + 2 > 255) ? 255 : used + 2));
        endcase
      end
      CMD_WRITE_FREE: begin
        if ($urandom_range(0, 3) != 0 && room > 0) off = 8'($urandom_range(0, room - 1));
      end
      CMD_COMMIT: begin
        if ($urandom_range(0, 3) != 0) cnt = 8'($urandom_range(0, room));
        if (cnt <= room) cnt = 8'(written_from_tail(cnt));
      end
      CMD_PEEK: begin
        if ($urandom_range(0, 3) != 0) off = 8'($urandom_range(0, used));
      end
      default: ;
    endcase
    send_command(op, random_node(), off, cnt);
  endtask

  // Random phases over a spread of ring sizes, each with one of the idling mixes in turn.
  task automatic test_random_phases();
    logic [CfgW-1:0] sizes [PHASES];
    int unsigned     start;
    sizes = '{9'd3, 9'd2, 9'd17, 9'd256, 9'd5, 9'd130, 9'd8, 9'd300, 9'd64, 9'd4};
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_slot_count(sizes[p]);
      set_idling(idle_mode_e'(p % 4));
      start = transfers_in;
      while (transfers_in - start < RANDOM_ITEMS / PHASES) send_random_command();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_RESET;
    cmd_if.node_data = '0;
    cmd_if.offset    = '0;
    cmd_if.count     = '0;
    res_if.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    error_count      = 0;
    transfers_in     = 0;
    results_seen     = 0;
    ring_slots       = ResetSlots;
    ring_head        = 0;
    ring_tail        = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ring();
    test_basic_ops();
    test_two_slot_ring();
    test_full_ring();
    test_random_phases();

    wait_results_drained();
    repeat (10) @(posedge clk_i);

    $display("sent %0d commands (reset %0d, enqueue %0d, burst %0d, drop %0d, write %0d,",
             transfers_in, op_hits[CMD_RESET], op_hits[CMD_ENQUEUE], op_hits[CMD_BURST],
             op_hits[CMD_DROP_HEAD], op_hits[CMD_WRITE_FREE]);
    $display("  commit %0d, peek %0d, peek last %0d), checked %0d results over ring sizes 2-256",
             op_hits[CMD_COMMIT], op_hits[CMD_PEEK], op_hits[CMD_PEEK_LAST], results_seen);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rqpb_pkg.sv
rtl/rqpb_cmd_if.sv
rtl/rqpb_res_if.sv
rtl/rqpb_ram.sv
rtl/rqpb_front.sv
rtl/rqpb_back.sv
rtl/ring_queue_with_peek_and_burst_unit.sv
tb/tb_top.sv
